// ===== hw/rtl/tx_power_swr_meter_assert.svh =====
// Assertion macros shared by the meter's RTL files.
`ifndef TX_POWER_SWR_METER_ASSERT_SVH
`define TX_POWER_SWR_METER_ASSERT_SVH

// A property that must hold at every edge outside reset.
`define TPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A property that must hold in the cycle after its trigger.
`define TPM_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

// ===== hw/rtl/tpm_pkg.sv =====
// Shared constants and types of the power and VSWR meter.
package tpm_pkg;
  localparam int AdcBits = 12;
  localparam int TrimPoints = 10;
  localparam int WBits = 25;
  localparam int TIdxBits = $clog2(TrimPoints + 1);
  localparam logic [WBits-1:0] WMax = '1;
  localparam logic [WBits-1:0] SpanGuard = 25'd66;
  localparam logic [WBits-1:0] FwdThresh = 25'd16384;
  localparam logic [16:0] GammaCap = 17'd62259;
  localparam logic [15:0] SwrOne = 16'd1024;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_TRIM   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_FWD_OFFSET = 3'd0,
    REG_REV_OFFSET = 3'd1,
    REG_FWD_GAIN   = 3'd2,
    REG_REV_GAIN_HF = 3'd3,
    REG_REV_GAIN_6M = 3'd4,
    REG_RATING     = 3'd5
  } reg_idx_t;

  // Request from the sequencer to the divider unit.
  typedef struct packed {
    logic        start;
    logic [79:0] num;
    logic [47:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [79:0] quo;
  } div_rsp_t;
endpackage

// ===== hw/rtl/tpm_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions but the divide by ten.
module tpm_div (
  input  logic              clk,
  input  logic              rst,
  input  tpm_pkg::div_req_t req,
  output tpm_pkg::div_rsp_t rsp
);
  import tpm_pkg::*;

  logic [79:0] quo;
  logic [48:0] rem;
  logic [47:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [48:0] trial;
  logic [48:0] shifted;

  always_comb begin
    shifted = {rem[47:0], quo[79]};
    trial = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo <= req.num;
        den <= req.den;
        rem <= '0;
        cnt <= 7'd80;
      end else if (busy) begin
        if (!trial[48]) begin
          rem <= trial;
          quo <= {quo[78:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[78:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo};

  `include "tx_power_swr_meter_assert.svh"
  `TPM_ASSERT(a_div_idle_start, !(req.start && busy), "divider started while busy")
  `TPM_ASSERT_NEXT(a_div_busy, req.start, busy, "divider did not go busy")
endmodule

// ===== hw/rtl/tpm_mul.sv =====
// 32x32 multiplier with registered product, used for squares and scaling.
module tpm_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end
endmodule

// ===== hw/rtl/tx_power_swr_meter.sv =====
// Top level of the transmit power and VSWR meter.
// Each request is handled alone by a sequencer around one 32x32 multiplier and one
// bit-serial divider: ready is low while it works. A clear, trim or unused
// command goes straight to the output state. For an update, each of the
// three coupler words needs a square and gain multiply, a breakpoint search
// of up to 11 steps, and a division on the trim curve that the span guard
// skips. VSWR then needs two divisions around a 32-step square root when
// the forward power is above threshold, and neither otherwise. The result
// is held in an output register until taken, and reports the readings
// after the request is processed.
module tx_power_swr_meter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [tpm_pkg::AdcBits-1:0]   fwd_raw,
  input  logic [tpm_pkg::AdcBits-1:0]   rev_raw,
  input  logic [tpm_pkg::AdcBits-1:0]   fwd_peak_raw,
  input  logic                          band_6m,
  input  logic [3:0]                    trim_index,
  input  logic [24:0]                   trim_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [24:0]                   fwd_watts,
  output logic [24:0]                   pep_watts,
  output logic [24:0]                   rev_watts,
  output logic [15:0]                   swr_value
);
  import tpm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SEL, S_SQ, S_SQW, S_GAIN, S_GAINW, S_SEARCH, S_SEG,
    S_TMUL, S_TMULW, S_TDIV, S_TDIVW, S_STORE, S_GDIV, S_GDIVW, S_SQRT,
    S_SMUL, S_SMULW, S_SDIV, S_SDIVW, S_RMUL, S_RMULW, S_OUT
  } state_t;

  state_t state;
  logic [AdcBits-1:0] fwd_offset, rev_offset;
  logic [31:0] fwd_gain, rev_gain_hf, rev_gain_6m;
  logic [9:0]  rating_watts;
  logic [WBits-1:0] trim_table [TrimPoints];
  logic [WBits-1:0] fwd_power, peak_power, rev_power;
  logic [15:0] swr_avg;

  logic [AdcBits-1:0] fwd_l, rev_l, peak_l;
  logic        band_l;
  logic [1:0]  chan;
  logic [WBits-1:0] p, lo, hi, res_w;
  logic [TIdxBits-1:0] seg, srch;
  logic [5:0]  step;
  logic [63:0] acc, rem_q, g;
  logic [31:0] ma, mb;
  logic [63:0] mp;
  div_req_t    dreq;
  div_rsp_t    drsp;

  tpm_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));
  tpm_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [AdcBits-1:0] raw_c, off_c, cnt_c;
  logic [31:0] gain_c;
  logic [WBits-1:0] b_at;
  logic [9:0]  rating_c;
  logic [63:0] sq_trial;
  logic [16:0] d_g;

  always_comb begin
    case (chan)
      2'd0: begin raw_c = fwd_l; off_c = fwd_offset; gain_c = fwd_gain; end
      2'd1: begin raw_c = peak_l; off_c = fwd_offset; gain_c = fwd_gain; end
      default: begin
        raw_c = rev_l; off_c = rev_offset;
        gain_c = band_l ? rev_gain_6m : rev_gain_hf;
      end
    endcase
    cnt_c = (raw_c > off_c) ? raw_c - off_c : '0;
    b_at = (srch == '0) ? '0 : trim_table[srch - TIdxBits'(1)];
    rating_c = (rating_watts == '0) ? 10'd100 : rating_watts;
    sq_trial = rem_q - (g | (64'd1 << {step, 1'b0}));
    d_g = 17'd65536 - g[16:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      in_ready <= 1'b0;
      out_valid <= 1'b0;
      dreq.start <= 1'b0;
      fwd_offset <= 12'd48;
      rev_offset <= 12'd42;
      fwd_gain <= 32'd53359;
      rev_gain_hf <= 32'd42687;
      rev_gain_6m <= 32'd9147;
      rating_watts <= 10'd100;
      fwd_power <= '0;
      peak_power <= '0;
      rev_power <= '0;
      swr_avg <= SwrOne;
      for (int k = 0; k < TrimPoints; k++) begin
        trim_table[k] <= WBits'((k + 1) * 10 * 65536);
      end
    end else begin
      dreq.start <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_FWD_OFFSET: fwd_offset <= cfg_data[AdcBits-1:0];
          REG_REV_OFFSET: rev_offset <= cfg_data[AdcBits-1:0];
          REG_FWD_GAIN: fwd_gain <= cfg_data;
          REG_REV_GAIN_HF: rev_gain_hf <= cfg_data;
          REG_REV_GAIN_6M: rev_gain_6m <= cfg_data;
          REG_RATING: rating_watts <= cfg_data[9:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          in_ready <= !out_valid || out_ready;
          if (out_valid && out_ready) out_valid <= 1'b0;
          if (in_valid && in_ready) begin
            in_ready <= 1'b0;
            fwd_l <= fwd_raw;
            rev_l <= rev_raw;
            peak_l <= fwd_peak_raw;
            band_l <= band_6m;
            chan <= 2'd0;
            state <= S_OUT;
            case (cmd)
              CMD_UPDATE: state <= S_SEL;
              CMD_CLEAR: begin
                fwd_power <= '0; peak_power <= '0; rev_power <= '0;
                swr_avg <= SwrOne;
              end
              CMD_TRIM: begin
                if (trim_index >= 4'd1 && 32'(trim_index) <= TrimPoints)
                  trim_table[trim_index[TIdxBits-1:0] - TIdxBits'(1)] <= trim_value;
              end
              default: ;
            endcase
          end
        end
        S_SEL: begin
          ma <= 32'(cnt_c);
          mb <= 32'(cnt_c);
          state <= S_SQ;
        end
        S_SQ: state <= S_SQW;
        S_SQW: begin
          ma <= mp[31:0];
          mb <= gain_c;
          state <= S_GAIN;
        end
        S_GAIN: state <= S_GAINW;
        S_GAINW: begin
          // The square has at most 32 bits, so the product fits 64 bits.
          p <= (mp[63:16] > 48'(WMax)) ? WMax : mp[WBits+15:16];
          srch <= '0;
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          // Walk breakpoints: stop at the first one not below the reading.
          if (p > trim_table[TrimPoints-1]) begin
            seg <= TIdxBits'(TrimPoints - 1);
            state <= S_SEG;
          end else if (32'(srch) < TrimPoints && p > b_at) begin
            srch <= srch + TIdxBits'(1);
          end else begin
            seg <= (srch == '0) ? '0 : srch - TIdxBits'(1);
            state <= S_SEG;
          end
        end
        S_SEG: begin
          lo <= (seg == '0) ? '0 : trim_table[seg - TIdxBits'(1)];
          hi <= trim_table[seg];
          state <= S_TMUL;
        end
        S_TMUL: begin
          if (27'(hi) < 27'(lo) + 27'(SpanGuard)) begin
            res_w <= hi;
            state <= S_STORE;
          end else begin
            ma <= 32'(seg);
            mb <= 32'(hi - lo);
            state <= S_TMULW;
          end
        end
        S_TMULW: state <= S_TDIV;
        S_TDIV: begin
          acc <= mp + 64'(p - lo);
          ma <= 32'({rating_c, 16'd0});
          state <= S_TDIVW;
          step <= 6'd0;
        end
        S_TDIVW: begin
          // Multiply the 29-bit sum by rating<<16 in two halves.
          if (step < 6'd4) step <= step + 6'd1;
          case (step)
            6'd0: mb <= acc[31:0];
            6'd1: mb <= 32'(acc[63:32]);
            6'd2: g <= mp;
            6'd3: begin
              dreq.num <= 80'(g) + (80'(mp) << 32);
              dreq.den <= 48'(hi - lo) * 48'd10;
              dreq.start <= 1'b1;
            end
            default: begin
              if (drsp.done) begin
                res_w <= (drsp.quo > 80'(WMax)) ? WMax : drsp.quo[WBits-1:0];
                state <= S_STORE;
              end
            end
          endcase
        end
        S_STORE: begin
          case (chan)
            2'd0: fwd_power <= res_w;
            2'd1: peak_power <= res_w;
            default: rev_power <= res_w;
          endcase
          if (chan == 2'd2) begin
            if (fwd_power > FwdThresh) begin
              dreq.num <= 80'(res_w) << 32;
              dreq.den <= 48'(fwd_power);
              dreq.start <= 1'b1;
              state <= S_GDIV;
            end else begin
              // Divide by ten with a reciprocal multiply; the sum stays below 2^18.
              ma <= 32'(swr_avg) * 32'd3 + 32'd7168;
              mb <= 32'hCCCCCCCD;
              state <= S_RMUL;
            end
          end else begin
            chan <= chan + 2'd1;
            state <= S_SEL;
          end
        end
        S_GDIV: state <= S_GDIVW;
        S_GDIVW: begin
          if (drsp.done) begin
            rem_q <= drsp.quo[63:0];
            g <= '0;
            step <= 6'd31;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          // Digit-by-digit square root, one result bit per cycle.
          if (!sq_trial[63] && rem_q >= (g | (64'd1 << {step, 1'b0}))) begin
            rem_q <= sq_trial;
            g <= (g >> 1) | (64'd1 << {step, 1'b0});
          end else begin
            g <= g >> 1;
          end
          if (step == 6'd0) state <= S_SMUL;
          else step <= step - 6'd1;
        end
        S_SMUL: begin
          if (g > 64'(GammaCap)) g <= 64'(GammaCap);
          state <= S_SMULW;
        end
        S_SMULW: begin
          dreq.num <= 80'd7168 * 80'(17'd65536 + g[16:0])
                      + 80'(swr_avg) * 80'd3 * 80'(d_g);
          dreq.den <= 48'(d_g) * 48'd10;
          dreq.start <= 1'b1;
          state <= S_SDIV;
        end
        S_SDIV: state <= S_SDIVW;
        S_SDIVW: begin
          if (drsp.done) begin
            swr_avg <= (drsp.quo > 80'hFFFF) ? 16'hFFFF : drsp.quo[15:0];
            state <= S_OUT;
          end
        end
        S_RMUL: state <= S_RMULW;
        S_RMULW: begin
          swr_avg <= mp[50:35];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign fwd_watts = fwd_power;
  assign pep_watts = peak_power;
  assign rev_watts = rev_power;
  assign swr_value = swr_avg;

  `include "tx_power_swr_meter_assert.svh"
  `TPM_ASSERT(a_ready_idle, !in_ready || state == S_IDLE, "ready outside idle")
  `TPM_ASSERT(a_ready_out, !(in_ready && out_valid && !out_ready), "ready over held result")
  `TPM_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "second accept")
endmodule

// ===== test/tb_tx_power_swr_meter.sv =====
// Self-checking testbench for the transmit power and VSWR meter.
`timescale 1ns / 1ps

module tb_tx_power_swr_meter;
  import tpm_pkg::*;

  localparam int WatchdogLimit = 40000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] fwd;
    logic [11:0] rev;
    logic [11:0] peak;
    logic        band;
    logic [3:0]  tidx;
    logic [24:0] tval;
  } meter_req_t;

  typedef struct packed {
    logic [24:0] fwd;
    logic [24:0] pep;
    logic [24:0] rev;
    logic [15:0] swr;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = '0;
  logic [11:0] fwd_raw = '0, rev_raw = '0, fwd_peak_raw = '0;
  logic band_6m = 1'b0;
  logic [3:0] trim_index = '0;
  logic [24:0] trim_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [24:0] fwd_watts, pep_watts, rev_watts;
  logic [15:0] swr_value;

  tx_power_swr_meter uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state of the meter.
  logic [63:0] m_fwd_off, m_rev_off, m_fwd_gain, m_gain_hf, m_gain_6m, m_rating;
  logic [63:0] m_fwd, m_peak, m_rev, m_swr;
  logic [63:0] m_trim [TrimPoints];

  reading_t readings_due[$];
  int errors = 0;
  int stall_cycles = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] trim_correct(logic [63:0] p);
    logic [63:0] bp [TrimPoints+1];
    logic [63:0] rating, lo, hi, span, res;
    logic [127:0] prod;
    int i;
    rating = (m_rating != 0) ? m_rating : 64'd100;
    bp[0] = 0;
    for (int k = 0; k < TrimPoints; k++) bp[k+1] = m_trim[k];
    i = 0;
    if (p > bp[TrimPoints]) begin
      i = TrimPoints - 1;
    end else begin
      while (i < TrimPoints && p > bp[i]) i++;
      if (i > 0) i--;
    end
    lo = bp[i];
    hi = bp[i+1];
    if (hi < lo + 64'd66) return hi;
    span = hi - lo;
    prod = 128'(rating) * 128'(65536) * 128'(64'(i) * span + (p - lo));
    res = 64'(prod / (128'd10 * 128'(span)));
    return (res > 64'd33554431) ? 64'd33554431 : res;
  endfunction

  function automatic logic [63:0] coupler_watts(logic [11:0] raw, logic [63:0] off,
                                                logic [63:0] gain);
    logic [63:0] c, w;
    logic [127:0] prod;
    c = (64'(raw) > off) ? 64'(raw) - off : 64'd0;
    prod = 128'(c * c) * 128'(gain);
    w = ((prod >> 16) > 128'd33554431) ? 64'd33554431 : 64'(prod >> 16);
    return trim_correct(w);
  endfunction

  function automatic reading_t meter_predict(meter_req_t r);
    logic [63:0] g, d, s;
    reading_t o;
    case (cmd_t'(r.cmd))
      CMD_UPDATE: begin
        m_fwd = coupler_watts(r.fwd, m_fwd_off, m_fwd_gain);
        m_peak = coupler_watts(r.peak, m_fwd_off, m_fwd_gain);
        m_rev = coupler_watts(r.rev, m_rev_off, r.band ? m_gain_6m : m_gain_hf);
        if (m_fwd > 64'(FwdThresh)) begin
          g = int_sqrt((m_rev << 32) / m_fwd);
          if (g > 64'(GammaCap)) g = 64'(GammaCap);
          d = 64'd65536 - g;
          s = (64'd7168 * (64'd65536 + g) + 64'd3 * m_swr * d) / (64'd10 * d);
        end else begin
          s = (64'd7168 + 64'd3 * m_swr) / 64'd10;
        end
        m_swr = (s > 64'hFFFF) ? 64'hFFFF : s;
      end
      CMD_CLEAR: begin
        m_fwd = 0;
        m_peak = 0;
        m_rev = 0;
        m_swr = 64'(SwrOne);
      end
      CMD_TRIM: begin
        if (r.tidx >= 1 && r.tidx <= TrimPoints) m_trim[r.tidx-1] = 64'(r.tval);
      end
      default: ;
    endcase
    o.fwd = m_fwd[24:0];
    o.pep = m_peak[24:0];
    o.rev = m_rev[24:0];
    o.swr = m_swr[15:0];
    return o;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(0, 3);
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FWD_OFFSET:  m_fwd_off = 64'(val[11:0]);
      REG_REV_OFFSET:  m_rev_off = 64'(val[11:0]);
      REG_FWD_GAIN:    m_fwd_gain = 64'(val);
      REG_REV_GAIN_HF: m_gain_hf = 64'(val);
      REG_REV_GAIN_6M: m_gain_6m = 64'(val);
      REG_RATING:      m_rating = 64'(val[9:0]);
      default: ;
    endcase
  endtask

  // Sends one request; if typed is set, the expected reading is checked to match want too.
  // Valid stays high into the next request when no gap follows; drain() drops it.
  task automatic send_request(meter_req_t r, bit typed = 0, reading_t want = '0);
    reading_t p;
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd <= r.cmd;
    fwd_raw <= r.fwd;
    rev_raw <= r.rev;
    fwd_peak_raw <= r.peak;
    band_6m <= r.band;
    trim_index <= r.tidx;
    trim_value <= r.tval;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = meter_predict(r);
    if (typed && p !== want) begin
      $display("%0t: table entry disagrees, expected %h got predicted %h", $time, want, p);
      errors++;
    end
    readings_due.push_back(p);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic meter_req_t rand_update();
    meter_req_t r;
    r = '0;
    r.cmd = CMD_UPDATE;
    r.fwd = 12'($urandom);
    r.peak = ($urandom_range(0, 1) == 0) ? r.fwd : 12'($urandom);
    r.rev = ($urandom_range(0, 2) == 0) ? 12'($urandom) : 12'($urandom_range(0, r.fwd));
    r.band = 1'($urandom);
    r.tidx = 4'($urandom);
    r.tval = 25'($urandom);
    return r;
  endfunction

  function automatic meter_req_t rand_request();
    meter_req_t r;
    int sel;
    r = rand_update();
    sel = $urandom_range(0, 99);
    if (sel < 5) r.cmd = CMD_CLEAR;
    else if (sel < 12) begin
      r.cmd = CMD_TRIM;
      if ($urandom_range(0, 4) != 0) r.tidx = 4'($urandom_range(1, 10));
      if ($urandom_range(0, 1) == 0) r.tval = 25'(64'(r.tidx) * 64'd655360 +
                                                 $urandom_range(0, 200000) - 100000);
    end else if (sel < 14) r.cmd = CMD_NONE;
    return r;
  endfunction

  // Receiver: random stalls, compare each reading with the oldest expectation.
  initial begin
    reading_t e;
    int gap;
    @(negedge clk);
    while (1) begin
      gap = pick_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected result %h %h %h %h", $time,
                 fwd_watts, pep_watts, rev_watts, swr_value);
        errors++;
      end else begin
        e = readings_due.pop_front();
        if (fwd_watts !== e.fwd) begin
          $display("%0t: fwd_watts expected %0d got %0d", $time, e.fwd, fwd_watts);
          errors++;
        end
        if (pep_watts !== e.pep) begin
          $display("%0t: pep_watts expected %0d got %0d", $time, e.pep, pep_watts);
          errors++;
        end
        if (rev_watts !== e.rev) begin
          $display("%0t: rev_watts expected %0d got %0d", $time, e.rev, rev_watts);
          errors++;
        end
        if (swr_value !== e.swr) begin
          $display("%0t: swr_value expected %0d got %0d", $time, e.swr, swr_value);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else if (readings_due.size() != 0 || in_valid)
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("FAIL tx_power_swr_meter");
      $finish;
    end
  end

  typedef struct {
    meter_req_t req;
    bit         typed;
    reading_t   want;
  } table_row_t;

  table_row_t rows [$];

  function automatic meter_req_t mk(cmd_t c, int f, int rv, int pk, bit b,
                                    int ti, int tv);
    meter_req_t r;
    r.cmd = c;
    r.fwd = 12'(f);
    r.rev = 12'(rv);
    r.peak = 12'(pk);
    r.band = b;
    r.tidx = 4'(ti);
    r.tval = 25'(tv);
    return r;
  endfunction

  initial begin
    m_fwd_off = 48; m_rev_off = 42; m_fwd_gain = 53359; m_gain_hf = 42687;
    m_gain_6m = 9147; m_rating = 100; m_fwd = 0; m_peak = 0; m_rev = 0;
    m_swr = 64'(SwrOne);
    for (int k = 0; k < TrimPoints; k++) m_trim[k] = 64'(k + 1) * 64'd655360;

    // Directed table: readings after reset, clamped words, extremes, trim edges.
    rows.push_back('{mk(CMD_NONE, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 1024}});
    rows.push_back('{mk(CMD_UPDATE, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 1024}});
    rows.push_back('{mk(CMD_UPDATE, 4095, 0, 4095, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_UPDATE, 4095, 4095, 4095, 1, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_UPDATE, 4095, 4095, 4095, 0, 15, 33554431), 0, '0});
    rows.push_back('{mk(CMD_UPDATE, 2000, 300, 3000, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_CLEAR, 4095, 4095, 4095, 1, 15, 33554431), 1,
                     '{0, 0, 0, 1024}});
    rows.push_back('{mk(CMD_TRIM, 0, 0, 0, 0, 0, 12345), 1, '{0, 0, 0, 1024}});
    rows.push_back('{mk(CMD_TRIM, 0, 0, 0, 0, 11, 12345), 1, '{0, 0, 0, 1024}});
    rows.push_back('{mk(CMD_TRIM, 0, 0, 0, 0, 15, 0), 1, '{0, 0, 0, 1024}});
    rows.push_back('{mk(CMD_TRIM, 0, 0, 0, 0, 1, 700000), 0, '0});
    rows.push_back('{mk(CMD_TRIM, 0, 0, 0, 0, 2, 700030), 0, '0});
    rows.push_back('{mk(CMD_TRIM, 0, 0, 0, 0, 3, 600000), 0, '0});
    rows.push_back('{mk(CMD_UPDATE, 1500, 200, 1600, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_UPDATE, 1650, 1650, 1700, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_TRIM, 0, 0, 0, 0, 10, 1000), 0, '0});
    rows.push_back('{mk(CMD_UPDATE, 3000, 2500, 4000, 1, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_TRIM, 0, 0, 0, 0, 10, 33554431), 0, '0});
    rows.push_back('{mk(CMD_UPDATE, 4095, 100, 4095, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 1024}});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].want);
    drain();

    // Random phases, each with its own register setting, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_FWD_OFFSET, 0); write_reg(REG_REV_OFFSET, 0);
          write_reg(REG_RATING, 1);
        end
        1: begin
          write_reg(REG_FWD_OFFSET, 4095); write_reg(REG_REV_OFFSET, 4095);
          write_reg(REG_FWD_GAIN, 32'hFFFFFFFF); write_reg(REG_RATING, 1000);
        end
        2: begin
          write_reg(REG_FWD_OFFSET, 48); write_reg(REG_REV_OFFSET, 42);
          write_reg(REG_FWD_GAIN, 0); write_reg(REG_REV_GAIN_HF, 32'hFFFFFFFF);
          write_reg(REG_REV_GAIN_6M, 0); write_reg(REG_RATING, 0);
        end
        3: begin
          write_reg(REG_FWD_GAIN, 53359); write_reg(REG_REV_GAIN_HF, 42687);
          write_reg(REG_REV_GAIN_6M, 9147); write_reg(REG_RATING, 100);
        end
        default: begin
          write_reg(REG_FWD_OFFSET, $urandom_range(0, 200));
          write_reg(REG_REV_OFFSET, $urandom_range(0, 200));
          write_reg(REG_FWD_GAIN, $urandom_range(10000, 2000000));
          write_reg(REG_REV_GAIN_HF, $urandom);
          write_reg(REG_REV_GAIN_6M, $urandom_range(1000, 100000));
          write_reg(REG_RATING, $urandom_range(0, 1023));
        end
      endcase
      // Reseed the trim grid most of the time so updates land in sane segments.
      if (ph != 1) begin
        for (int k = 1; k <= TrimPoints; k++)
          send_request(mk(CMD_TRIM, 0, 0, 0, 0, k,
                          k * ($urandom_range(1, 4) * 655360) / 2));
      end
      repeat (140) send_request(rand_request());
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("PASS tx_power_swr_meter");
    end else begin
      $display("FAIL tx_power_swr_meter");
    end
    $finish;
  end
endmodule
